### hdl/mep_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
// No dependencies; imported by mep_core, mandelbrot_escape_pixel and the testbench.
`default_nettype none

package mep_pkg;

    localparam int FRAC_BITS          = 28;
    localparam int IMAGE_WIDTH        = 512;
    localparam int MAX_ITERATIONS_DEF = 255;

    localparam int DATA_W = 32;   // config register width
    localparam int POS_W  = 9;    // pixel column / row width
    localparam int IDX_W  = 18;   // frame buffer index width
    localparam int COL_W  = 8;    // colour component width
    localparam int CFG_AW = 3;    // config index width

    localparam int C_W   = 42;    // exact c = start + pos * step
    localparam int N_W   = 44;    // unclamped z' before range check
    localparam int Z_W   = 31;    // z component after range check, |z| <= 2.0
    localparam int SQ_W  = 59;    // z component squared
    localparam int MUL_W = 32;
    localparam int PRD_W = 64;

    localparam logic [CFG_AW-1:0] REG_START_RE = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_START_IM = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_STEP_RE  = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_STEP_IM  = CFG_AW'(3);

    localparam logic signed [DATA_W-1:0] START_RE_RST = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] START_IM_RST = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] STEP_RE_RST  = 32'sd2684355;
    localparam logic signed [DATA_W-1:0] STEP_IM_RST  = 32'sd2684355;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_RE,
        ST_C_IM,
        ST_INIT,
        ST_UPDATE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CROSS,
        ST_DONE
    } mep_state_t;

    typedef struct packed {
        logic start;   // launch a pixel, valid while idle
        logic ack;     // count taken into the output register
    } mep_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } mep_sts_t;

    // x mod 255 by folding bytes (256 == 1 mod 255)
    function automatic logic [COL_W-1:0] mep_mod255(input logic [15:0] x);
        logic [8:0] s;
        logic [8:0] t;
        s = {1'b0, x[7:0]} + {1'b0, x[15:8]};
        t = {1'b0, s[7:0]} + {8'd0, s[8]};
        if (t >= 9'd255) begin
            t = t - 9'd255;
        end
        return t[COL_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/mep_core.sv
// Escape-time iteration engine: one shared 32x32 multiplier under a small sequencer.
// Depends on mep_pkg.
`default_nettype none

module mep_core #(
    parameter int MAX_ITERATIONS = mep_pkg::MAX_ITERATIONS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire mep_pkg::mep_ctl_t                        ctl,
    output mep_pkg::mep_sts_t                             sts,
    input  wire logic [mep_pkg::POS_W-1:0]                pixel_col,
    input  wire logic [mep_pkg::POS_W-1:0]                pixel_row,
    input  wire logic signed [mep_pkg::DATA_W-1:0]        start_re,
    input  wire logic signed [mep_pkg::DATA_W-1:0]        start_im,
    input  wire logic signed [mep_pkg::DATA_W-1:0]        step_re,
    input  wire logic signed [mep_pkg::DATA_W-1:0]        step_im,
    output logic [$clog2(MAX_ITERATIONS+1)-1:0]           count
);
    import mep_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITERATIONS);
    localparam logic signed [N_W-1:0] LIM_POS = N_W'(1) << (FRAC_BITS + 1);
    localparam logic signed [N_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic [SQ_W:0] FOUR_Q56 = (SQ_W + 1)'(1) << (2 * FRAC_BITS + 2);

    mep_state_t state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic signed [C_W-1:0] c_re_reg, c_re_next;
    logic signed [C_W-1:0] c_im_reg, c_im_next;
    logic signed [Z_W-1:0] re_reg, re_next;
    logic signed [Z_W-1:0] im_reg, im_next;
    logic [SQ_W-1:0] rr_reg, rr_next;
    logic [SQ_W-1:0] ii_reg, ii_next;
    logic signed [PRD_W-1:0] prod_reg;

    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PRD_W-1:0] diff;
    logic signed [N_W-1:0] nre;
    logic signed [N_W-1:0] nim;
    logic out_of_range;
    logic [SQ_W:0] mag_sum;

    always_comb begin
        diff = $signed({{(PRD_W-SQ_W){1'b0}}, rr_reg})
             - $signed({{(PRD_W-SQ_W){1'b0}}, ii_reg});
        nre = N_W'(diff >>> FRAC_BITS) + N_W'(c_re_reg);
        // floor(2*re*im / 2^28) == floor(re*im / 2^27)
        nim = N_W'(prod_reg >>> (FRAC_BITS - 1)) + N_W'(c_im_reg);
        out_of_range = (nre > LIM_POS) || (nre < LIM_NEG)
                    || (nim > LIM_POS) || (nim < LIM_NEG);
        mag_sum = {1'b0, rr_reg} + {1'b0, prod_reg[SQ_W-1:0]};
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        c_re_next  = c_re_reg;
        c_im_next  = c_im_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        mul_a      = '0;
        mul_b      = '0;
        sts.idle   = 1'b0;
        sts.done   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                sts.idle = 1'b1;
                if (ctl.start) begin
                    col_next   = pixel_col;
                    row_next   = pixel_row;
                    state_next = ST_C_RE;
                end
            end
            ST_C_RE: begin
                mul_a      = MUL_W'(col_reg);
                mul_b      = step_re;
                state_next = ST_C_IM;
            end
            ST_C_IM: begin
                c_re_next  = C_W'(start_re) + C_W'(prod_reg);
                mul_a      = MUL_W'(row_reg);
                mul_b      = step_im;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                // zero operands leave re*im == 0 for the first update
                c_im_next  = C_W'(start_im) + C_W'(prod_reg);
                n_next     = '0;
                rr_next    = '0;
                ii_next    = '0;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (n_reg == CNT_MAX || out_of_range) begin
                    state_next = ST_DONE;
                end else begin
                    re_next    = Z_W'(nre);
                    im_next    = Z_W'(nim);
                    state_next = ST_SQ_RE;
                end
            end
            ST_SQ_RE: begin
                mul_a      = MUL_W'(re_reg);
                mul_b      = MUL_W'(re_reg);
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM: begin
                rr_next    = prod_reg[SQ_W-1:0];
                mul_a      = MUL_W'(im_reg);
                mul_b      = MUL_W'(im_reg);
                state_next = ST_CROSS;
            end
            ST_CROSS: begin
                ii_next = prod_reg[SQ_W-1:0];
                if (mag_sum > FOUR_Q56) begin
                    state_next = ST_DONE;
                end else begin
                    mul_a      = MUL_W'(re_reg);
                    mul_b      = MUL_W'(im_reg);
                    n_next     = n_reg + CNT_W'(1);
                    state_next = ST_UPDATE;
                end
            end
            ST_DONE: begin
                sts.done = 1'b1;
                if (ctl.ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        c_re_reg <= c_re_next;
        c_im_reg <= c_im_next;
        re_reg   <= re_next;
        im_reg   <= im_next;
        rr_reg   <= rr_next;
        ii_reg   <= ii_next;
        prod_reg <= mul_a * mul_b;
    end

    assign count = n_reg;

    a_start_launches: assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.idle && ctl.start) |=> (state_reg == ST_C_RE))
        else $error("start not taken by idle engine");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (n_reg <= CNT_MAX))
        else $error("iteration count beyond limit");

    a_z_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ_RE) |->
            ((N_W'(re_reg) <= LIM_POS) && (N_W'(re_reg) >= LIM_NEG)
             && (N_W'(im_reg) <= LIM_POS) && (N_W'(im_reg) >= LIM_NEG)))
        else $error("z component outside +/-2.0 after range check");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.done && !ctl.ack) |=> sts.done)
        else $error("finished count dropped before it was taken");

endmodule

`default_nettype wire

### hdl/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel evaluator: view registers,
// input capture, gradient colour and output register. Depends on mep_pkg, mep_core.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_pixel_col, s_pixel_row
//  m_        out        m_valid / m_ready      m_escape_count, m_red, m_green, m_blue,
//                                              m_pixel_index
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One pixel at a time. Each iteration runs ST_UPDATE, ST_SQ_RE, ST_SQ_IM and ST_CROSS in
// turn around the single shared 32x32 multiplier (three products per iteration plus the
// update step). s_ready rises again once the count moves into the output register, so
// the next pixel can run while the previous result waits on m_ready. Reset is synchronous
// on aresetn and loads the default view.
`default_nettype none

module mandelbrot_escape_pixel #(
    parameter int MAX_ITERATIONS = mep_pkg::MAX_ITERATIONS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [mep_pkg::POS_W-1:0]      s_pixel_col,
    input  wire logic [mep_pkg::POS_W-1:0]      s_pixel_row,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [mep_pkg::COL_W-1:0]           m_escape_count,
    output logic [mep_pkg::COL_W-1:0]           m_red,
    output logic [mep_pkg::COL_W-1:0]           m_green,
    output logic [mep_pkg::COL_W-1:0]           m_blue,
    output logic [mep_pkg::IDX_W-1:0]           m_pixel_index,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mep_pkg::CFG_AW-1:0]     cfg_index,
    input  wire logic [mep_pkg::DATA_W-1:0]     cfg_data
);
    import mep_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

    logic signed [DATA_W-1:0] start_re_reg;
    logic signed [DATA_W-1:0] start_im_reg;
    logic signed [DATA_W-1:0] step_re_reg;
    logic signed [DATA_W-1:0] step_im_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             m_valid_reg, m_valid_next;
    logic [COL_W-1:0] cnt_out_reg;
    logic [COL_W-1:0] red_reg;
    logic [COL_W-1:0] green_reg;
    logic [COL_W-1:0] blue_reg;
    logic [IDX_W-1:0] idx_out_reg;

    mep_ctl_t         ctl;
    mep_sts_t         sts;
    logic [CNT_W-1:0] count;
    logic             s_accept;
    logic [15:0]      cnt_ext;

    assign cfg_ready = 1'b1;
    assign s_ready   = sts.idle;
    assign s_accept  = s_valid && s_ready;
    assign ctl.start = s_accept;
    assign ctl.ack   = sts.done && (!m_valid_reg || m_ready);
    assign cnt_ext   = 16'(count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_re_reg <= START_RE_RST;
            start_im_reg <= START_IM_RST;
            step_re_reg  <= STEP_RE_RST;
            step_im_reg  <= STEP_IM_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_RE: start_re_reg <= cfg_data;
                REG_START_IM: start_im_reg <= cfg_data;
                REG_STEP_RE:  step_re_reg  <= cfg_data;
                REG_STEP_IM:  step_im_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    mep_core #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .pixel_col (s_pixel_col),
        .pixel_row (s_pixel_row),
        .start_re  (start_re_reg),
        .start_im  (start_im_reg),
        .step_re   (step_re_reg),
        .step_im   (step_im_reg),
        .count     (count)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.ack) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            idx_reg <= IDX_W'(32'(s_pixel_row) * IMAGE_WIDTH + 32'(s_pixel_col));
        end
        if (ctl.ack) begin
            cnt_out_reg <= COL_W'(count);
            red_reg     <= mep_mod255(16'(cnt_ext * 16'd5));
            green_reg   <= mep_mod255(16'(cnt_ext * 16'd2));
            blue_reg    <= mep_mod255(cnt_ext);
            idx_out_reg <= idx_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_escape_count = cnt_out_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_pixel_index  = idx_out_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("second transaction accepted while a pixel is in flight");

    a_ack_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ack |=> m_valid)
        else $error("finished count did not reach the output register");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !ctl.ack)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for mandelbrot_escape_pixel: directed and randomized pixels over several
// view settings, each result checked against an escape-time predictor kept inside the bench.
// Depends on mep_pkg and the mandelbrot_escape_pixel RTL.
`timescale 1ns / 1ps

module tb;
    import mep_pkg::*;

    localparam int ITER_LIMIT     = MAX_ITERATIONS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam longint TWO_Q28    = longint'(1) << (FRAC_BITS + 1);
    localparam longint FOUR_Q56   = longint'(1) << (2 * FRAC_BITS + 2);

    typedef struct packed {
        logic [COL_W-1:0] count;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic [IDX_W-1:0] index;
    } pixel_result_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [POS_W-1:0]  s_pixel_col;
    logic [POS_W-1:0]  s_pixel_row;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [COL_W-1:0]  m_escape_count;
    logic [COL_W-1:0]  m_red;
    logic [COL_W-1:0]  m_green;
    logic [COL_W-1:0]  m_blue;
    logic [IDX_W-1:0]  m_pixel_index;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    logic signed [DATA_W-1:0] view_start_re;
    logic signed [DATA_W-1:0] view_start_im;
    logic signed [DATA_W-1:0] view_step_re;
    logic signed [DATA_W-1:0] view_step_im;

    pixel_result_t expected_pixels [$];
    int unsigned   fail_count   = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   stall_left   = 0;
    bit            idle_on      = 1'b1;

    mandelbrot_escape_pixel #(
        .MAX_ITERATIONS(ITER_LIMIT)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_escape_count(m_escape_count),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_pixel_index (m_pixel_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic pixel_result_t predict_pixel(input logic [POS_W-1:0] col,
                                                    input logic [POS_W-1:0] row);
        pixel_result_t r;
        longint c_re;
        longint c_im;
        longint re;
        longint im;
        longint nre;
        longint nim;
        int unsigned n;
        c_re = longint'(view_start_re) + longint'(col) * longint'(view_step_re);
        c_im = longint'(view_start_im) + longint'(row) * longint'(view_step_im);
        re = 0;
        im = 0;
        n = 0;
        while (n < ITER_LIMIT) begin
            nre = ((re * re - im * im) >>> FRAC_BITS) + c_re;
            nim = ((2 * re * im) >>> FRAC_BITS) + c_im;
            if ((nre < 0 ? -nre : nre) > TWO_Q28 || (nim < 0 ? -nim : nim) > TWO_Q28) begin
                break;
            end
            if (nre * nre + nim * nim > FOUR_Q56) begin
                break;
            end
            re = nre;
            im = nim;
            n++;
        end
        r.count = COL_W'(n);
        r.red   = COL_W'((n * 5) % 255);
        r.green = COL_W'((n * 2) % 255);
        r.blue  = COL_W'(n % 255);
        r.index = IDX_W'(longint'(row) * IMAGE_WIDTH + longint'(col));
        return r;
    endfunction

    task automatic wait_pixels_drained();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
        pixel_result_t want;
        want = predict_pixel(col, row);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel_col <= col;
        s_pixel_row <= row;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.push_back(want);
    endtask

    task automatic set_view(input logic [DATA_W-1:0] sre, input logic [DATA_W-1:0] sim,
                            input logic [DATA_W-1:0] stre, input logic [DATA_W-1:0] stim);
        logic [CFG_AW-1:0] regs [4];
        logic [DATA_W-1:0] vals [4];
        regs = '{REG_START_RE, REG_START_IM, REG_STEP_RE, REG_STEP_IM};
        vals = '{sre, sim, stre, stim};
        wait_pixels_drained();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid     <= 1'b0;
        view_start_re = sre;
        view_start_im = sim;
        view_step_re  = stre;
        view_step_im  = stim;
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++) begin
            send_pixel(POS_W'($urandom_range(0, 511)), POS_W'($urandom_range(0, 511)));
            if ($urandom_range(0, 99) == 0) begin
                wait_pixels_drained();
            end
        end
    endtask

    // default view straight out of reset: corners, interior, near-boundary points
    task automatic test_reset_view();
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd0, 9'd511);
        send_pixel(9'd200, 9'd200);
        send_pixel(9'd150, 9'd210);
        send_pixel(9'd100, 9'd200);
    endtask

    task automatic test_view_extremes();
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd1, 9'd1);
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(9'd511, 9'd0);
        // c = 0 everywhere: never escapes
        set_view(32'h0, 32'h0, 32'h0, 32'h0);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        // points on the radius-2 circle, the origin, and points outside it
        set_view(32'hE000_0000, 32'h0, 32'h2000_0000, 32'h2000_0001);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd1, 9'd0);
        send_pixel(9'd2, 9'd0);
        send_pixel(9'd0, 9'd1);
        send_pixel(9'd3, 9'd0);
    endtask

    task automatic test_random_views();
        logic [DATA_W-1:0] v [4];
        set_view(START_RE_RST, START_IM_RST, STEP_RE_RST, STEP_IM_RST);
        send_random_pixels(350);
        set_view(32'hE000_0000, 32'hEC00_0000, 32'd1310720, 32'd1310720);
        send_random_pixels(250);
        set_view(-32'sd214748365, 32'sd13421773, 32'sd53687, 32'sd53687);
        send_random_pixels(150);
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < 4; i++) begin
                if ($urandom_range(0, 1) == 0) begin
                    v[i] = $urandom;
                end else if (i < 2) begin
                    v[i] = DATA_W'($urandom_range(0, 1342177280)) - 32'd671088640;
                end else begin
                    v[i] = DATA_W'($urandom_range(0, 4194304)) - 32'd2097152;
                end
            end
            set_view(v[0], v[1], v[2], v[3]);
            send_random_pixels(40);
        end
        set_view(32'h2000_0000, 32'h2000_0000, -32'sd1342177, -32'sd1342177);
        send_random_pixels(100);
    endtask

    task automatic test_no_idle();
        set_view(START_RE_RST, START_IM_RST, STEP_RE_RST, STEP_IM_RST);
        idle_on = 1'b0;
        send_random_pixels(100);
    endtask

    always @(posedge aclk) begin : result_backpressure
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        pixel_result_t got;
        pixel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.count = m_escape_count;
            got.red   = m_red;
            got.green = m_green;
            got.blue  = m_blue;
            got.index = m_pixel_index;
            if (expected_pixels.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: count=%0d rgb=%0d/%0d/%0d index=%0d",
                             got.count, got.red, got.green, got.blue, got.index);
                end
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got.count !== want.count || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.index !== want.index) begin
                    if (fail_count < 10) begin
                        $display("mismatch: exp count=%0d rgb=%0d/%0d/%0d index=%0d",
                                 want.count, want.red, want.green, want.blue, want.index);
                        $display("          got count=%0d rgb=%0d/%0d/%0d index=%0d",
                                 got.count, got.red, got.green, got.blue, got.index);
                    end
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_pixel_col   = '0;
        s_pixel_row   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_START_RE;
        cfg_data      = '0;
        view_start_re = START_RE_RST;
        view_start_im = START_IM_RST;
        view_step_re  = STEP_RE_RST;
        view_step_im  = STEP_IM_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_view();
        test_view_extremes();
        test_random_views();
        test_no_idle();

        wait_pixels_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
